// File: hdl/range_median_validity_hold_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range median / validity hold core
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RANGE_MEDIAN_VALIDITY_HOLD_CORE_MACROS_SVH
`define RANGE_MEDIAN_VALIDITY_HOLD_CORE_MACROS_SVH

// Checked on every edge outside reset
`define RMVH_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define RMVH_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rmvh_pkg.sv
// ----------------------------------------------------------------------------
// rmvh_pkg
// Types, widths and register codes of the range median / validity hold core.
// ----------------------------------------------------------------------------
package rmvh_pkg;

    // Field widths
    localparam int RANGE_W    = 16;
    localparam int STATUS_W   = 8;
    localparam int STAMP_W    = 32;
    localparam int CODE_W     = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Device error field inside the status byte (mask 0x78)
    localparam int ERR_LSB = 3;
    localparam int ERR_MSB = 6;

    // Default ring length
    localparam int RING_DEPTH_DEF = 5;

    // Register reset values
    localparam logic [RANGE_W-1:0] HOLD_MS_RST    = 16'd500;
    localparam logic [CODE_W-1:0]  OK_CODE_RST    = 4'd11;
    localparam logic [RANGE_W-1:0] OOR_CODE_RST   = 16'd8190;
    localparam logic [RANGE_W-1:0] WIN_LOW_RST    = 16'd20;
    localparam logic [RANGE_W-1:0] WIN_HIGH_RST   = 16'd8190;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_MS     = 3'd0,
        CFG_OK_CODE     = 3'd1,
        CFG_OOR_CODE    = 3'd2,
        CFG_WINDOW_LOW  = 3'd3,
        CFG_WINDOW_HIGH = 3'd4
    } cfg_idx_e;

    // Input item
    typedef struct packed {
        logic [RANGE_W-1:0]  range_mm;
        logic [STATUS_W-1:0] status_byte;
        logic [STAMP_W-1:0]  now_ms;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [RANGE_W-1:0] held_range;
        logic               healthy;
        logic               in_window;
        logic [CODE_W-1:0]  device_error;
    } out_item_t;

    // Contents of one ring cell
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [CODE_W-1:0]  code;
    } cell_data_t;

endpackage

// File: hdl/range_median_validity_hold_core.sv
// ----------------------------------------------------------------------------
// range_median_validity_hold_core
// Median-of-ring range filter with a timeout hold on unhealthy readings.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one reading item (range, status byte, timestamp);
//   out_valid/out_ready carry one result item per reading, in order.
//   cfg_we/cfg_index/cfg_data write one of the five registers at a time; write
//   them only while no item is in flight. Unknown indexes are ignored.
//   Each accepted reading shifts into a chain of ring cells as stage 1
//   takes its metadata; stage 2 then registers the median and health
//   flag; the output stage updates the hold value and stamp and registers
//   the result. Throughput: one item per cycle while the output is not
//   stalled; every stage is a register, and the hold update (one 32-bit
//   subtract and compare) is the only feedback path. A stalled output
//   holds its item; upstream stages keep filling, so up to two more items
//   are taken before in_ready drops.
//   Reset clears the ring to zero, the hold value and stamp to zero, the
//   registers to their defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module range_median_validity_hold_core
    import rmvh_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [RANGE_W-1:0] hold_ms_reg,     hold_ms_next;
    logic [CODE_W-1:0]  ok_code_reg,     ok_code_next;
    logic [RANGE_W-1:0] oor_code_reg,    oor_code_next;
    logic [RANGE_W-1:0] win_low_reg,     win_low_next;
    logic [RANGE_W-1:0] win_high_reg,    win_high_next;

    // Pipeline registers
    logic               s1_valid_reg,    s1_valid_next;
    logic [CODE_W-1:0]  s1_err_reg,      s1_err_next;
    logic [STAMP_W-1:0] s1_now_reg,      s1_now_next;
    logic               s2_valid_reg,    s2_valid_next;
    logic [CODE_W-1:0]  s2_err_reg,      s2_err_next;
    logic [STAMP_W-1:0] s2_now_reg,      s2_now_next;
    logic [RANGE_W-1:0] s2_median_reg,   s2_median_next;
    logic               s2_healthy_reg,  s2_healthy_next;
    logic               out_valid_reg,   out_valid_next;
    out_item_t          out_item_reg,    out_item_next;

    // Hold state
    logic [RANGE_W-1:0] held_value_reg,  held_value_next;
    logic [STAMP_W-1:0] held_stamp_reg,  held_stamp_next;

    // Handshake and datapath nets
    logic               s2_adv;
    logic               s1_adv;
    logic               accept;
    logic [CODE_W-1:0]  in_err;
    logic [STAMP_W-1:0] elapsed;
    logic               timeout;
    logic [RANGE_W-1:0] held_upd;
    logic [STAMP_W-1:0] stamp_upd;
    logic               ring_healthy;
    logic [RANGE_W-1:0] ring_median;

    cell_data_t         cell_d     [RING_DEPTH];
    cell_data_t         cell_q     [RING_DEPTH];
    logic [RANGE_W-1:0] cell_range [RING_DEPTH];
    logic [RING_DEPTH-1:0] cell_match;

    // Stage enables: a stage moves when its successor is empty or moving
    assign s2_adv   = !out_valid_reg || out_ready;
    assign s1_adv   = !s2_valid_reg || s2_adv;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;
    assign in_err   = in_item.status_byte[ERR_MSB:ERR_LSB];

    // Ring as a chain of cells; newest reading enters at cell 0
    generate
        for (genvar i = 0; i < RING_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign cell_d[i] = '{range_mm: in_item.range_mm, code: in_err};
            end
            else
            begin : g_body
                assign cell_d[i] = cell_q[i-1];
            end

            rmvh_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (accept),
                .ok_code (ok_code_reg),
                .d       (cell_d[i]),
                .q       (cell_q[i]),
                .match   (cell_match[i])
            );

            assign cell_range[i] = cell_q[i].range_mm;
        end
    endgenerate

    assign ring_healthy = &cell_match;

    rmvh_median #(
        .DEPTH (RING_DEPTH)
    ) u_median (
        .ranges (cell_range),
        .median (ring_median)
    );

    // Configuration writes
    always_comb
    begin
        hold_ms_next  = hold_ms_reg;
        ok_code_next  = ok_code_reg;
        oor_code_next = oor_code_reg;
        win_low_next  = win_low_reg;
        win_high_next = win_high_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_HOLD_MS:     hold_ms_next  = cfg_data;
                CFG_OK_CODE:     ok_code_next  = cfg_data[CODE_W-1:0];
                CFG_OOR_CODE:    oor_code_next = cfg_data;
                CFG_WINDOW_LOW:  win_low_next  = cfg_data;
                CFG_WINDOW_HIGH: win_high_next = cfg_data;
                default:         ;
            endcase
        end
    end

    // Stage 1: reading metadata, ring already shifted
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_err_next   = s1_err_reg;
        s1_now_next   = s1_now_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
            s1_err_next   = in_err;
            s1_now_next   = in_item.now_ms;
        end
    end

    // Stage 2: median and health of the ring
    always_comb
    begin
        s2_valid_next   = s2_valid_reg;
        s2_err_next     = s2_err_reg;
        s2_now_next     = s2_now_reg;
        s2_median_next  = s2_median_reg;
        s2_healthy_next = s2_healthy_reg;
        if (s1_adv)
        begin
            s2_valid_next   = s1_valid_reg;
            s2_err_next     = s1_err_reg;
            s2_now_next     = s1_now_reg;
            s2_median_next  = ring_median;
            s2_healthy_next = ring_healthy;
        end
    end

    // Hold update: healthy takes the median, else time out to the substitute
    assign elapsed = s2_now_reg - held_stamp_reg;
    assign timeout = elapsed > {{(STAMP_W-RANGE_W){1'b0}}, hold_ms_reg};

    always_comb
    begin
        held_upd  = held_value_reg;
        stamp_upd = held_stamp_reg;
        priority if (s2_healthy_reg)
        begin
            held_upd  = s2_median_reg;
            stamp_upd = s2_now_reg;
        end
        else if (timeout)
        begin
            held_upd  = oor_code_reg;
            stamp_upd = s2_now_reg;
        end
        else
        begin
            // unhealthy within the hold time: keep value and stamp
            held_upd  = held_value_reg;
            stamp_upd = held_stamp_reg;
        end
    end

    // Output stage and hold registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        held_value_next = held_value_reg;
        held_stamp_next = held_stamp_reg;
        if (s2_adv)
        begin
            out_valid_next = s2_valid_reg;
            if (s2_valid_reg)
            begin
                held_value_next = held_upd;
                held_stamp_next = stamp_upd;
                out_item_next.held_range   = held_upd;
                out_item_next.healthy      = s2_healthy_reg;
                out_item_next.in_window    = (held_upd > win_low_reg) &&
                                             (held_upd < win_high_reg);
                out_item_next.device_error = s2_err_reg;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg    <= HOLD_MS_RST;
            ok_code_reg    <= OK_CODE_RST;
            oor_code_reg   <= OOR_CODE_RST;
            win_low_reg    <= WIN_LOW_RST;
            win_high_reg   <= WIN_HIGH_RST;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_value_reg <= '0;
            held_stamp_reg <= '0;
        end
        else
        begin
            hold_ms_reg    <= hold_ms_next;
            ok_code_reg    <= ok_code_next;
            oor_code_reg   <= oor_code_next;
            win_low_reg    <= win_low_next;
            win_high_reg   <= win_high_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= out_valid_next;
            held_value_reg <= held_value_next;
            held_stamp_reg <= held_stamp_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_err_reg     <= s1_err_next;
        s1_now_reg     <= s1_now_next;
        s2_err_reg     <= s2_err_next;
        s2_now_reg     <= s2_now_next;
        s2_median_reg  <= s2_median_next;
        s2_healthy_reg <= s2_healthy_next;
        out_item_reg   <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: hdl/rmvh_cell.sv
// ----------------------------------------------------------------------------
// rmvh_cell
// One ring cell: holds a range and its error code, takes its neighbor's
// contents on each shift and flags whether its code is the good code.
// ----------------------------------------------------------------------------
module rmvh_cell
    import rmvh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  logic [CODE_W-1:0]  ok_code,
    input  cell_data_t         d,
    output cell_data_t         q,
    output logic               match
);

    cell_data_t data_reg;
    cell_data_t data_next;

    // Load from the left neighbor on a shift
    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q     = data_reg;
    assign match = (data_reg.code == ok_code);

endmodule

// File: hdl/rmvh_median.sv
// ----------------------------------------------------------------------------
// rmvh_median
// Rank-select median: each entry counts the entries ordered before it
// (value, then position on ties); the entry of middle rank is picked.
// ----------------------------------------------------------------------------
module rmvh_median
    import rmvh_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
)
(
    input  logic [RANGE_W-1:0] ranges [DEPTH],
    output logic [RANGE_W-1:0] median
);

    localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [RANK_W-1:0] MED_RANK = RANK_W'(DEPTH / 2);

    logic [RANK_W-1:0] rank [DEPTH];

    // Pairwise compares, counted per entry
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < DEPTH; j++)
            begin
                if (j != i)
                begin
                    if ((ranges[j] < ranges[i]) || ((ranges[j] == ranges[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    // Exactly one entry holds the middle rank
    always_comb
    begin
        median = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (rank[i] == MED_RANK)
            begin
                median = median | ranges[i];
            end
        end
    end

endmodule

// File: hdl/rmvh_checker.sv
// ----------------------------------------------------------------------------
// rmvh_checker
// Port-level checks of the range median / validity hold core.
// ----------------------------------------------------------------------------
`include "range_median_validity_hold_core_macros.svh"

module rmvh_checker
    import rmvh_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_item
);

    // A stalled result item stays put
    `RMVH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result item changed while stalled")

    // Reset empties the output
    `RMVH_ASSERT_ALWAYS(a_rst_empty, !rst_n |-> !out_valid, "result shown during reset")

    // With the output empty the input side never stalls
    `RMVH_ASSERT(a_no_false_stall, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind range_median_validity_hold_core rmvh_checker u_rmvh_checker (.*);

// File: bench/range_median_validity_hold_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_median_validity_hold_core_tb
// Self-checking bench for the median-of-five range filter with timeout hold.
// Readings are pushed through the valid/ready input with random gaps, results
// are drained with random stalls, and each result is compared field by field
// with a behavioral filter kept in step with every accepted reading.
// ----------------------------------------------------------------------------
module range_median_validity_hold_core_tb;
    import rmvh_pkg::*;

    localparam int RING_DEPTH      = RING_DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_ITEMS     = 320;
    localparam int STALL_ITEMS     = 40;

    // First register index that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_WINDOW_HIGH + 1);

    // DUT signals
    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Filter model: register copies
    logic [RANGE_W-1:0] reg_hold_ms;
    logic [CODE_W-1:0]  reg_ok_code;
    logic [RANGE_W-1:0] reg_oor_code;
    logic [RANGE_W-1:0] reg_win_low;
    logic [RANGE_W-1:0] reg_win_high;

    // Filter model: ring and hold state
    logic [RANGE_W-1:0] filt_ranges [RING_DEPTH];
    logic [CODE_W-1:0]  filt_codes  [RING_DEPTH];
    int                 filt_slot;
    logic [RANGE_W-1:0] filt_held;
    logic [STAMP_W-1:0] filt_stamp;

    // Results still owed by the block, oldest first
    out_item_t pending_results [$];

    int                 error_count;
    bit                 src_idle_on;
    bit                 sink_idle_on;
    bit                 hold_off_req;
    logic [STAMP_W-1:0] now_cursor;

    range_median_validity_hold_core #(
        .RING_DEPTH (RING_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------------

    // Store one reading in the ring and return the result it should produce
    function automatic out_item_t filter_reading(input in_item_t rd);
        out_item_t          res;
        logic [CODE_W-1:0]  err;
        logic [RANGE_W-1:0] sorted [RING_DEPTH];
        logic [RANGE_W-1:0] tmp;
        logic [STAMP_W-1:0] elapsed;
        bit                 all_ok;
        err = rd.status_byte[ERR_MSB:ERR_LSB];
        filt_ranges[filt_slot] = rd.range_mm;
        filt_codes[filt_slot]  = err;
        filt_slot = (filt_slot == RING_DEPTH - 1) ? 0 : filt_slot + 1;

        all_ok = 1'b1;
        foreach (filt_codes[i])
            if (filt_codes[i] != reg_ok_code)
                all_ok = 1'b0;

        elapsed = rd.now_ms - filt_stamp;
        if (all_ok)
        begin
            // median: bubble sort a copy and take the middle entry
            sorted = filt_ranges;
            for (int i = 1; i < RING_DEPTH; i++)
                for (int j = RING_DEPTH - 1; j >= i; j--)
                    if (sorted[j-1] > sorted[j])
                    begin
                        tmp         = sorted[j];
                        sorted[j]   = sorted[j-1];
                        sorted[j-1] = tmp;
                    end
            filt_held  = sorted[RING_DEPTH / 2];
            filt_stamp = rd.now_ms;
        end
        else if (elapsed > reg_hold_ms)
        begin
            filt_held  = reg_oor_code;
            filt_stamp = rd.now_ms;
        end

        res.held_range   = filt_held;
        res.healthy      = all_ok;
        res.in_window    = (filt_held > reg_win_low) && (filt_held < reg_win_high);
        res.device_error = err;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic in_item_t reading(input logic [RANGE_W-1:0] dist_mm,
                                         input logic [STATUS_W-1:0] status,
                                         input logic [STAMP_W-1:0] stamp);
        in_item_t rd;
        rd.range_mm    = dist_mm;
        rd.status_byte = status;
        rd.now_ms      = stamp;
        return rd;
    endfunction

    // Status byte carrying a given error code, other bits from noise
    function automatic logic [STATUS_W-1:0] make_status(input logic [CODE_W-1:0] code,
                                                        input logic [STATUS_W-1:0] noise);
        logic [STATUS_W-1:0] status;
        status = noise;
        status[ERR_MSB:ERR_LSB] = code;
        return status;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int idle_gap(input bit enabled);
        int pick;
        if (!enabled)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Register value: often an extreme, otherwise anywhere in range
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_DATA_W-1:0] top);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return '0;
        if (pick < 4)
            return top;
        return CFG_DATA_W'($urandom_range(0, top));
    endfunction

    // Random reading: good codes mostly, ranges near the window edges at
    // times, timestamps that creep, jump, go backwards or hit the hold edge
    function automatic in_item_t random_reading(input int bad_pct);
        in_item_t          rd;
        logic [CODE_W-1:0] code;
        int                pick;
        code = ($urandom_range(0, 99) < bad_pct) ? CODE_W'($urandom) : reg_ok_code;
        rd.status_byte = make_status(code, STATUS_W'($urandom));

        pick = $urandom_range(0, 11);
        if (pick == 0)
            rd.range_mm = reg_win_low;
        else if (pick == 1)
            rd.range_mm = reg_win_low + 1'b1;
        else if (pick == 2)
            rd.range_mm = reg_win_high - 1'b1;
        else if (pick == 3)
            rd.range_mm = reg_win_high;
        else
            rd.range_mm = RANGE_W'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 4)
            now_cursor = $urandom;
        else if (pick < 10)
            now_cursor = now_cursor - $urandom_range(1, 1000);
        else if (pick < 30)
            now_cursor = filt_stamp + reg_hold_ms + $urandom_range(0, 1);
        else
            now_cursor = now_cursor + $urandom_range(0, 60);
        rd.now_ms = now_cursor;
        return rd;
    endfunction

    // Offer one reading and wait until it is taken; in_valid stays high
    // afterwards so back-to-back readings follow without a gap
    task automatic send_reading(input in_item_t rd);
        int gap;
        gap = idle_gap(src_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= rd;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(filter_reading(rd));
    endtask

    // Stop offering and let every owed result come out
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_HOLD_MS:     reg_hold_ms  = value;
            CFG_OK_CODE:     reg_ok_code  = value[CODE_W-1:0];
            CFG_OOR_CODE:    reg_oor_code = value;
            CFG_WINDOW_LOW:  reg_win_low  = value;
            CFG_WINDOW_HIGH: reg_win_high = value;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zeroed ring after reset reports unhealthy until five good codes land;
    // then the median is held, kept at the hold edge, replaced one ms past it
    task automatic test_startup_fill();
        logic [RANGE_W-1:0] fill [5] = '{16'hFFFF, 16'h0000, 16'd300, 16'd7000, 16'd21};
        send_reading(reading(16'd1234, make_status(4'hF, 8'hFF), 32'd0));
        for (int k = 0; k < 5; k++)
            send_reading(reading(fill[k], make_status(OK_CODE_RST, (k % 2) ? 8'h87 : 8'h00),
                                 32'd10 * (k + 1)));
        send_reading(reading(16'd5, make_status(4'h0, 8'h00), 32'd550));
        send_reading(reading(16'd5, make_status(4'h0, 8'h80), 32'd551));
    endtask

    // Timestamps wrap through zero: a small forward step holds, a step
    // backwards reads as a huge elapsed time
    task automatic test_stamp_wrap();
        logic [RANGE_W-1:0] fill [5] = '{16'd20, 16'd21, 16'd8189, 16'd8190, 16'd20};
        for (int k = 0; k < 5; k++)
            send_reading(reading(fill[k], make_status(OK_CODE_RST, STATUS_W'($urandom)),
                                 32'hFFFF_FFE0 + 4 * k));
        send_reading(reading(16'd100, make_status(4'h3, 8'h07), 32'h0000_0005));
        send_reading(reading(16'd100, make_status(4'h3, 8'h00), 32'hFFFF_FF00));
    endtask

    // Both ends of every register; spare indexes must not disturb anything
    task automatic test_register_extremes();
        logic [RANGE_W-1:0] fill [5] = '{16'hFFFF, 16'd1, 16'd2, 16'hFFFF, 16'hFFFF};
        logic [STAMP_W-1:0] base;
        settle_pipeline();
        write_reg(CFG_HOLD_MS, 16'd0);
        write_reg(CFG_OK_CODE, 16'hFFF0);
        write_reg(CFG_OOR_CODE, 16'd0);
        write_reg(CFG_WINDOW_LOW, 16'd0);
        write_reg(CFG_WINDOW_HIGH, 16'hFFFF);
        base = filt_stamp;
        send_reading(reading(16'd42, make_status(4'h5, 8'h00), base));
        send_reading(reading(16'd42, make_status(4'h5, 8'h00), base + 1));

        settle_pipeline();
        write_reg(CFG_HOLD_MS, 16'hFFFF);
        write_reg(CFG_OK_CODE, 16'hFFFF);
        write_reg(CFG_OOR_CODE, 16'hFFFF);
        write_reg(CFG_WINDOW_LOW, 16'hFFFF);
        write_reg(CFG_WINDOW_HIGH, 16'd0);
        for (int i = CFG_IDX_SPARE; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 16'h5A5A);
        base = filt_stamp;
        for (int k = 0; k < 5; k++)
            send_reading(reading(fill[k], 8'hFF, base + k));
        base = filt_stamp;
        send_reading(reading(16'd7, make_status(4'h0, 8'h00), base + 32'd65535));
        send_reading(reading(16'd7, make_status(4'h0, 8'h00), base + 32'd65536));
    endtask

    // Receiver holds off long while readings keep coming; the block must
    // fill, drop in_ready and lose nothing
    task automatic test_output_stall();
        settle_pipeline();
        src_idle_on  = 1'b0;
        hold_off_req = 1'b1;
        wait (!hold_off_req);
        for (int k = 0; k < STALL_ITEMS; k++)
            send_reading(random_reading(20));
        src_idle_on = 1'b1;
    endtask

    // Phases of random readings, each under its own register setting
    task automatic test_random_phases();
        int bad_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle_pipeline();
            if (phase == 0)
            begin
                write_reg(CFG_HOLD_MS, HOLD_MS_RST);
                write_reg(CFG_OK_CODE, CFG_DATA_W'(OK_CODE_RST));
                write_reg(CFG_OOR_CODE, OOR_CODE_RST);
                write_reg(CFG_WINDOW_LOW, WIN_LOW_RST);
                write_reg(CFG_WINDOW_HIGH, WIN_HIGH_RST);
            end
            else
            begin
                write_reg(CFG_HOLD_MS, pick_reg_value(16'hFFFF));
                write_reg(CFG_OK_CODE, (CFG_DATA_W'($urandom) << CODE_W) |
                                       pick_reg_value(16'd15));
                write_reg(CFG_OOR_CODE, pick_reg_value(16'hFFFF));
                write_reg(CFG_WINDOW_LOW, pick_reg_value(16'hFFFF));
                write_reg(CFG_WINDOW_HIGH, pick_reg_value(16'hFFFF));
            end
            bad_pct = $urandom_range(5, 45);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // switch idling per stretch so some stretches run flat out
                if (k % 80 == 0)
                begin
                    src_idle_on  = ($urandom_range(0, 3) != 0);
                    sink_idle_on = ($urandom_range(0, 3) != 0);
                end
                send_reading(random_reading(bad_pct));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_HOLD_MS;
        cfg_data  <= '0;

        reg_hold_ms  = HOLD_MS_RST;
        reg_ok_code  = OK_CODE_RST;
        reg_oor_code = OOR_CODE_RST;
        reg_win_low  = WIN_LOW_RST;
        reg_win_high = WIN_HIGH_RST;
        foreach (filt_ranges[i])
        begin
            filt_ranges[i] = '0;
            filt_codes[i]  = '0;
        end
        filt_slot    = 0;
        filt_held    = '0;
        filt_stamp   = '0;
        error_count  = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_off_req = 1'b0;
        now_cursor   = $urandom;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_fill();
        test_stamp_wrap();
        test_register_extremes();
        test_output_stall();
        test_random_phases();

        settle_pipeline();
        if (error_count == 0)
            $display("PASS range_median_validity_hold_core");
        else
            $display("FAIL range_median_validity_hold_core");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int run_len;
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                run_len = $urandom_range(1, 12);
                repeat (run_len) @(posedge clk);
                gap = idle_gap(sink_idle_on);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest owed result
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no reading owed, expected none, actual %p",
                         $time, out_item);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("held_range", 32'(want.held_range), 32'(out_item.held_range));
                check_field("healthy", 32'(want.healthy), 32'(out_item.healthy));
                check_field("in_window", 32'(want.in_window), 32'(out_item.in_window));
                check_field("device_error", 32'(want.device_error),
                            32'(out_item.device_error));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles with no item moving on either side
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL range_median_validity_hold_core");
        $finish;
    end

endmodule
